// ----- src/sptc_pkg.sv -----
// Package for the segment path crossing test block.
// Sizes, transaction kind codes, orientation codes and the point type.
// No dependencies.
package sptc_pkg;

    localparam int MAX_POINTS = 256;
    localparam int COORD_BITS = 16;

    localparam int PTR_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int KIND_BITS  = 2;
    localparam int FIRST_BITS = 8;

    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int VAL_BITS   = PROD_BITS + 1;

    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] ORI_ZERO = 2'd0;
    localparam logic [1:0] ORI_POS  = 2'd1;
    localparam logic [1:0] ORI_NEG  = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

endpackage

// ----- src/segment_path_crossing_test_top.sv -----
// Top level of the segment path crossing test block: point store, sequencer
// and the shared orientation multiplier.
// Depends on sptc_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, kind, start_x/y, end_x/y | into block
//  out     | out_valid, out_stall, status, crosses,    | out of block
//          | first_segment                             |
//
// Clear, append and unused kinds, and a query with fewer than three points, are
// answered without a test; any other query uses the single multiplier, which
// forms eight cross products per path segment tested.
// The point store and its read register have no reset; all other registers clear.
// A result waits in the output register while out_stall is high; in_stall
// stays high while a query runs or a result cannot be placed.
module segment_path_crossing_test_top
    import sptc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [KIND_BITS-1:0]         kind,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic                         crosses,
    output logic [FIRST_BITS-1:0]        first_segment
);

    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_MUL_LAST = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_DECIDE   = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD0,
        S_LOAD1,
        S_LOAD2,
        S_TEST,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [PTR_BITS-1:0]    seg_idx_reg, seg_idx_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    point_t                 a_reg, a_next, b_reg, b_next;
    point_t                 c_reg, c_next, d_reg, d_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic signed [PROD_BITS-1:0] acc_reg, acc_next;
    logic [3:0][1:0]        ori_reg, ori_next;
    logic [3:0]             box_reg, box_next;
    logic                   hit_reg, hit_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   status_reg, status_next;
    logic                   crosses_reg, crosses_next;
    logic [FIRST_BITS-1:0]  first_reg, first_next;

    point_t                 path_mem [MAX_POINTS];
    point_t                 rd_data_reg;
    logic [PTR_BITS-1:0]    rd_addr;
    logic                   wr_en;

    logic                   accept;
    logic                   slot_free;
    logic [1:0]             mul_ori;
    logic                   mul_phase;
    logic [2:0]             hold_idx;
    point_t                 op_p, op_q, op_r;
    logic signed [DIFF_BITS-1:0] f1, f2;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [VAL_BITS-1:0]  val;
    logic [1:0]             val_code;
    logic                   in_box;
    logic                   meet;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && slot_free);
    assign accept    = in_valid && !in_stall;
    assign wr_en     = accept && (kind == KIND_APPEND) && (count_reg < CNT_BITS'(MAX_POINTS));

    always_comb
    begin
        case (state_reg)
            S_LOAD0: rd_addr = '0;
            S_LOAD1: rd_addr = PTR_BITS'(1);
            default: rd_addr = PTR_BITS'(CNT_BITS'(seg_idx_reg) + CNT_BITS'(2));
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            path_mem[count_reg[PTR_BITS-1:0]] <= '{x: start_x, y: start_y};
        end
        rd_data_reg <= path_mem[rd_addr];
    end

    // shared orientation unit: one product per step, orientation = step / 2
    assign mul_ori   = step_reg[2:1];
    assign mul_phase = step_reg[0];
    assign hold_idx  = 3'(step_reg - STEP_BITS'(1));

    always_comb
    begin
        case (mul_ori)
            2'd0:    begin op_p = a_reg; op_q = b_reg; op_r = c_reg; end
            2'd1:    begin op_p = a_reg; op_q = b_reg; op_r = d_reg; end
            2'd2:    begin op_p = c_reg; op_q = d_reg; op_r = a_reg; end
            default: begin op_p = c_reg; op_q = d_reg; op_r = b_reg; end
        endcase
    end

    always_comb
    begin
        if (!mul_phase)
        begin
            f1 = DIFF_BITS'(op_q.y) - DIFF_BITS'(op_p.y);
            f2 = DIFF_BITS'(op_r.x) - DIFF_BITS'(op_q.x);
        end
        else
        begin
            f1 = DIFF_BITS'(op_q.x) - DIFF_BITS'(op_p.x);
            f2 = DIFF_BITS'(op_r.y) - DIFF_BITS'(op_q.y);
        end
    end

    assign prod = f1 * f2;
    assign val  = VAL_BITS'(acc_reg) - VAL_BITS'(prod_reg);

    always_comb
    begin
        if (val == '0)
            val_code = ORI_ZERO;
        else if (!val[VAL_BITS-1])
            val_code = ORI_POS;
        else
            val_code = ORI_NEG;
    end

    // r inside the bounding box of p and q
    assign in_box = ((op_r.x >= op_p.x && op_r.x <= op_q.x) ||
                     (op_r.x >= op_q.x && op_r.x <= op_p.x)) &&
                    ((op_r.y >= op_p.y && op_r.y <= op_q.y) ||
                     (op_r.y >= op_q.y && op_r.y <= op_p.y));

    assign meet = ((ori_reg[0] != ori_reg[1]) && (ori_reg[2] != ori_reg[3])) ||
                  ((ori_reg[0] == ORI_ZERO) && box_reg[0]) ||
                  ((ori_reg[1] == ORI_ZERO) && box_reg[1]) ||
                  ((ori_reg[2] == ORI_ZERO) && box_reg[2]) ||
                  ((ori_reg[3] == ORI_ZERO) && box_reg[3]);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        seg_idx_next   = seg_idx_reg;
        step_next      = step_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        ori_next       = ori_reg;
        box_next       = box_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        crosses_next   = crosses_reg;
        first_next     = first_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    a_next = '{x: start_x, y: start_y};
                    b_next = '{x: end_x, y: end_y};
                    seg_idx_next = '0;
                    hit_next = 1'b0;
                    status_next  = 1'b0;
                    crosses_next = 1'b0;
                    first_next   = '0;
                    if (kind == KIND_QUERY && count_reg >= CNT_BITS'(3))
                    begin
                        state_next = S_LOAD0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (kind == KIND_CLEAR)
                            count_next = '0;
                        else if (kind == KIND_APPEND)
                        begin
                            if (wr_en)
                                count_next = count_reg + CNT_BITS'(1);
                            else
                                status_next = 1'b1;
                        end
                    end
                end
            end
            S_LOAD0:
            begin
                state_next = S_LOAD1;
            end
            S_LOAD1:
            begin
                c_next = rd_data_reg;
                state_next = S_LOAD2;
            end
            S_LOAD2:
            begin
                d_next = rd_data_reg;
                step_next = '0;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (step_reg <= STEP_MUL_LAST)
                begin
                    prod_next = prod;
                    if (mul_phase)
                        box_next[mul_ori] = in_box;
                end
                if (step_reg != '0 && step_reg < STEP_DECIDE)
                begin
                    if (!hold_idx[0])
                        acc_next = prod_reg;
                    else
                        ori_next[hold_idx[2:1]] = val_code;
                end
                if (step_reg == STEP_DECIDE)
                begin
                    step_next = '0;
                    if (meet)
                    begin
                        hit_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (CNT_BITS'(seg_idx_reg) + CNT_BITS'(3) < count_reg)
                    begin
                        seg_idx_next = seg_idx_reg + PTR_BITS'(1);
                        c_next = d_reg;
                        d_next = rd_data_reg;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    step_next = step_reg + STEP_BITS'(1);
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next  = 1'b0;
                    crosses_next = hit_reg;
                    first_next   = hit_reg ? FIRST_BITS'(seg_idx_reg) : '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            seg_idx_reg   <= '0;
            step_reg      <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            ori_reg       <= '0;
            box_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= 1'b0;
            crosses_reg   <= 1'b0;
            first_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            seg_idx_reg   <= seg_idx_next;
            step_reg      <= step_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            ori_reg       <= ori_next;
            box_reg       <= box_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            crosses_reg   <= crosses_next;
            first_reg     <= first_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign crosses       = crosses_reg;
    assign first_segment = first_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_POINTS))
        else $error("point count above capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_APPEND && count_reg == CNT_BITS'(MAX_POINTS))
        |=> (out_valid && status && $stable(count_reg)))
        else $error("append to full store not flagged");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> (CNT_BITS'(seg_idx_reg) + CNT_BITS'(2) < count_reg))
        else $error("segment walk past stored points");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(status && crosses))
        else $error("status and crosses both set");

endmodule
